FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros included by the occlusion block's RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk out of reset.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on the rising edge of clk out of reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/glos_pkg.sv
// ----------------------------------------------------------------------------
// glos_pkg
// Types and constants of the grid line-of-sight occlusion block.
// ----------------------------------------------------------------------------
package glos_pkg;

  // Field widths of the items and registers
  localparam int COL_W      = 5;
  localparam int ROW_W      = 4;
  localparam int DIST_W     = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // Cell coordinates widened to 7 bits, enough for grid sizes up to 127
  localparam int CELL_EXT_W = 7;

  // Half-cell geometry and cross products
  localparam int ORI_W = 16;
  typedef logic signed [ORI_W-1:0] ori_t;

  // Item kinds
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VIEWER_COL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWER_ROW = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP1,
    ST_SETUP2,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // True when both values are non-zero and of opposite sign
  function automatic logic opp_sign(input ori_t a, input ori_t b);
    return ((a < 0) && (b > 0)) || ((a > 0) && (b < 0));
  endfunction

endpackage

FILE: src/grid_line_of_sight_occlusion.sv
// The scan reads one map cell per cycle from the map RAM; map writes are taken one
// per cycle while idle. A new query or write is accepted only in the idle state,
// not while a query is in progress.
// Reset: synchronous, active low; afterwards a clearing pass writes floor to every
// cell of the 2**(clog2 rows + clog2 cols)-entry map RAM, items wait.
// ----------------------------------------------------------------------------
// grid_line_of_sight_occlusion
// Wall map in a single-port-write RAM; a query sweeps the map, testing the
// sight segment against both diagonals of each wall cell but the target's own.
// ----------------------------------------------------------------------------
module grid_line_of_sight_occlusion
  import glos_pkg::*;
#(
  parameter int GRID_ROWS = 16,
  parameter int GRID_COLS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // cell_col[4:0], cell_row[8:5], wall_value[9]
  input  logic                  in_tuser,   // op[0]
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // occluded[0], target_wall[1], dist_sq[12:2]
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 2 ** AW;

  // Input fields
  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;
  logic             in_wall;
  logic             in_inside;

  assign in_col    = in_tdata[COL_W-1:0];
  assign in_row    = in_tdata[COL_W+ROW_W-1:COL_W];
  assign in_wall   = in_tdata[COL_W+ROW_W];
  assign in_inside = (CELL_EXT_W'(in_col) < CELL_EXT_W'(GRID_COLS)) &&
                     (CELL_EXT_W'(in_row) < CELL_EXT_W'(GRID_ROWS));

  // Configuration registers
  logic [COL_W-1:0] viewer_col_r;
  logic [ROW_W-1:0] viewer_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      viewer_col_r <= '0;
      viewer_row_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_VIEWER_COL: viewer_col_r <= cfg_wdata[COL_W-1:0];
        REG_VIEWER_ROW: viewer_row_r <= cfg_wdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state
  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_r;
  logic [RW-1:0]       scan_row_r;
  logic [CW-1:0]       scan_col_r;
  logic                scan_last;
  logic                clr_last;
  logic                in_acc;
  logic                load_out;
  logic                issue;
  logic                out_valid_r;

  // Map RAM ports
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic                mem_wd;
  logic [AW-1:0]       mem_ra;
  logic                rd_q_r;
  logic                mem [DEPTH];

  logic [CELL_EXT_W-1:0] in_row_ext, in_col_ext;
  logic [AW-1:0]         tgt_addr;

  assign in_row_ext = CELL_EXT_W'(in_row);
  assign in_col_ext = CELL_EXT_W'(in_col);
  assign tgt_addr   = {in_row_ext[RW-1:0], in_col_ext[CW-1:0]};

  assign scan_last = (scan_row_r == RW'(GRID_ROWS - 1)) && (scan_col_r == CW'(GRID_COLS - 1));
  assign clr_last  = (clr_r == {AW{1'b1}});

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_tvalid && (in_tuser == OP_QUERY)) state_nxt = ST_SETUP1;
      ST_SETUP1: state_nxt = ST_SETUP2;
      ST_SETUP2: state_nxt = ST_SCAN;
      ST_SCAN:   if (scan_last) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    issue     = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = tgt_addr;
    mem_wd    = in_wall;
    mem_ra    = tgt_addr;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = 1'b0;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        mem_we    = in_tvalid && (in_tuser == OP_WRITE) && in_inside;
      end
      ST_SCAN: begin
        issue  = 1'b1;
        mem_ra = {scan_row_r, scan_col_r};
      end
      ST_DONE:  load_out = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + AW'(1);
    end
  end

  // Map RAM, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q_r <= mem[mem_ra];
  end

  // Query registers
  logic [CELL_EXT_W-1:0] tgt_row_r, tgt_col_r;
  logic                  tgt_inside_r;
  ori_t                  px_r, py_r, dx_r, dy_r, dx2_r, dy2_r, dc_r, dr_r;
  ori_t                  kp1_r, kt1_r, kp2_r, kt2_r;
  ori_t                  prod_r, s_r, srow_r;
  logic [DIST_W-1:0]     dcsq_r, dist_r;
  logic                  tw_r, occ_r;

  // Capture the query and set up the sweep
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tgt_row_r    <= in_row_ext;
      tgt_col_r    <= in_col_ext;
      tgt_inside_r <= in_inside;
      px_r  <= ori_t'({viewer_col_r, 1'b1});
      py_r  <= ori_t'({viewer_row_r, 1'b1});
      dx_r  <= ori_t'({in_col, 1'b1}) - ori_t'({viewer_col_r, 1'b1});
      dy_r  <= ori_t'({in_row, 1'b1}) - ori_t'({viewer_row_r, 1'b1});
      dx2_r <= ori_t'({in_col, 2'b10}) - ori_t'({viewer_col_r, 2'b10});
      dy2_r <= ori_t'({in_row, 2'b10}) - ori_t'({viewer_row_r, 2'b10});
      dc_r  <= ori_t'(in_col) - ori_t'(viewer_col_r);
      dr_r  <= ori_t'(in_row) - ori_t'(viewer_row_r);
      kp1_r <= ori_t'({viewer_row_r, 1'b1}) - ori_t'({viewer_col_r, 1'b1});
      kt1_r <= ori_t'({in_row, 1'b1}) - ori_t'({in_col, 1'b1});
      kp2_r <= ori_t'(viewer_row_r) + ori_t'(viewer_col_r) + ori_t'(viewer_row_r)
               + ori_t'(viewer_col_r);
      kt2_r <= ori_t'(in_row) + ori_t'(in_col) + ori_t'(in_row) + ori_t'(in_col);
    end
    // cross product at the grid origin: dy*px - dx*py, formed in ST_SETUP1 and ST_SETUP2
    if (state_r == ST_SETUP1) begin
      tw_r   <= tgt_inside_r && rd_q_r;
      prod_r <= ori_t'(dy_r * px_r);
      dcsq_r <= DIST_W'(ori_t'(dc_r * dc_r));
    end
    if (state_r == ST_SETUP2) begin
      s_r    <= prod_r - ori_t'(dx_r * py_r);
      srow_r <= prod_r - ori_t'(dx_r * py_r);
      dist_r <= dcsq_r + DIST_W'(ori_t'(dr_r * dr_r));
    end else if (issue) begin
      if (scan_col_r == CW'(GRID_COLS - 1)) begin
        s_r    <= srow_r + dx2_r;
        srow_r <= srow_r + dx2_r;
      end else begin
        s_r <= s_r - dy2_r;
      end
    end
  end

  // Sweep counters
  always_ff @(posedge clk) begin
    if (state_r == ST_SETUP2) begin
      scan_row_r <= '0;
      scan_col_r <= '0;
    end else if (issue) begin
      if (scan_col_r == CW'(GRID_COLS - 1)) begin
        scan_col_r <= '0;
        scan_row_r <= scan_row_r + RW'(1);
      end else begin
        scan_col_r <= scan_col_r + CW'(1);
      end
    end
  end

  // Stage alongside the RAM read: cell geometry of the issued cell
  logic vld1_r, skip1_r;
  ori_t s1_r, u1_r, v1_r;
  ori_t cell_x, cell_y;

  assign cell_x = ori_t'({scan_col_r, 1'b0});
  assign cell_y = ori_t'({scan_row_r, 1'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) vld1_r <= 1'b0;
    else        vld1_r <= issue;
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_r    <= s_r;
      u1_r    <= cell_x - cell_y;
      v1_r    <= cell_x + cell_y;
      skip1_r <= (CELL_EXT_W'(scan_row_r) == tgt_row_r) &&
                 (CELL_EXT_W'(scan_col_r) == tgt_col_r);
    end
  end

  // Wall test: segment splits a diagonal and a diagonal splits the segment
  ori_t s_b, s_c, s_d, e1p, e1t, e2p, e2t;
  logic seg_split, diag_split, blk;

  assign s_b = s1_r + dx2_r;
  assign s_c = s1_r + dx2_r - dy2_r;
  assign s_d = s1_r - dy2_r;
  assign e1p = kp1_r + u1_r;
  assign e1t = kt1_r + u1_r;
  assign e2p = kp2_r - v1_r;
  assign e2t = kt2_r - v1_r;
  assign seg_split  = opp_sign(s1_r, s_c) || opp_sign(s_b, s_d);
  assign diag_split = opp_sign(e1p, e1t) || opp_sign(e2p, e2t);
  assign blk = vld1_r && rd_q_r && !skip1_r && seg_split && diag_split;

  always_ff @(posedge clk) begin
    if (state_r == ST_SETUP2) occ_r <= 1'b0;
    else if (blk)             occ_r <= 1'b1;
  end

  // Output register
  logic [OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_data_r <= OUT_DATA_W'({dist_r, tw_r, occ_r});
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Assertions
  `include "assert_macros.svh"

  `ASSERT_IMPLIES(a_no_accept_in_clear, state_r == ST_CLEAR, !in_tready)
  `ASSERT_NEXT(a_result_from_done, !out_valid_r && state_r != ST_DONE, !out_valid_r)
  `ASSERT_IMPLIES(a_write_when_idle, mem_we, state_r == ST_IDLE || state_r == ST_CLEAR)
  `ASSERT_IMPLIES(a_test_in_sweep, vld1_r, state_r == ST_SCAN || state_r == ST_DRAIN)

endmodule
